/* rtl/iiu_pkg.sv */
// Shared types and constants of the intensity interval union block.
// No dependencies; used by every module under rtl/.
package iiu_pkg;

   localparam int MAX_INTERVALS_DEF = 16;

   localparam int MEAN_W   = 16;
   localparam int SPREAD_W = 16;
   localparam int FACTOR_W = 12;
   localparam int OPEN_W   = 2;
   localparam int LOW_W    = 16;
   localparam int HIGH_W   = 21;
   localparam int BOUND_W  = 22;
   localparam int FRAC_W   = 8;
   localparam int PROD_W   = FACTOR_W + SPREAD_W;
   localparam int OFF_W    = PROD_W - FRAC_W;
   localparam int ROUND_HALF = 1 << (FRAC_W - 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SPREAD_FACTOR = 1'b0;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 12'd512;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   localparam logic [OPEN_W-1:0] OPEN_LOW  = 2'd1;
   localparam logic [OPEN_W-1:0] OPEN_HIGH = 2'd2;

   localparam logic signed [BOUND_W-1:0] TOP_LEVEL = 22'sd65535;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic                      op;
      logic signed [BOUND_W-1:0] lo;
      logic signed [BOUND_W-1:0] hi;
   } item_type;

   typedef struct packed {
      logic full;
      logic avail;
   } qstat_type;

endpackage

/* rtl/iiu_front.sv */
// Front end: takes command beats, scales the spread and forms the interval bounds.
// Depends on iiu_pkg; feeds iiu_queue.
module iiu_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_operation,
   input  logic [iiu_pkg::MEAN_W-1:0]       req_class_mean,
   input  logic [iiu_pkg::SPREAD_W-1:0]     req_class_spread,
   input  logic [iiu_pkg::OPEN_W-1:0]       req_open_end,
   input  logic [iiu_pkg::FACTOR_W-1:0]     spread_factor,
   input  iiu_pkg::qstat_type               qstat,
   output logic                             push,
   output iiu_pkg::item_type                item
);

   logic                              s1_v_ff, s1_v_in;
   logic                              s1_op_ff;
   logic [iiu_pkg::MEAN_W-1:0]        s1_mean_ff;
   logic [iiu_pkg::SPREAD_W-1:0]      s1_spread_ff;
   logic [iiu_pkg::OPEN_W-1:0]        s1_open_ff;

   logic                              s2_v_ff, s2_v_in;
   logic                              s2_op_ff;
   logic [iiu_pkg::MEAN_W-1:0]        s2_mean_ff;
   logic [iiu_pkg::OPEN_W-1:0]        s2_open_ff;
   logic [iiu_pkg::PROD_W-1:0]        prod_ff, prod_in;

   logic                              accept, s1_go, s2_go;
   logic [iiu_pkg::PROD_W-1:0]        rounded;
   logic [iiu_pkg::OFF_W-1:0]         offset;
   logic signed [iiu_pkg::BOUND_W-1:0] mean_s, off_s, lo_raw, hi_raw, lo_adj, hi_adj;

   assign s2_go  = s2_v_ff && !qstat.full;
   assign s1_go  = s1_v_ff && (!s2_v_ff || s2_go);
   assign busy   = s1_v_ff && !s1_go;
   assign accept = start && !busy;

   assign s1_v_in = accept || (s1_v_ff && !s1_go);
   assign s2_v_in = s1_go || (s2_v_ff && !s2_go);
   assign prod_in = iiu_pkg::PROD_W'(spread_factor) * iiu_pkg::PROD_W'(s1_spread_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
      if (accept) begin
         s1_op_ff     <= req_operation;
         s1_mean_ff   <= req_class_mean;
         s1_spread_ff <= req_class_spread;
         s1_open_ff   <= req_open_end;
      end
      if (s1_go) begin
         s2_op_ff   <= s1_op_ff;
         s2_mean_ff <= s1_mean_ff;
         s2_open_ff <= s1_open_ff;
         prod_ff    <= prod_in;
      end
   end

   // round half up, then drop the fraction of the Q20.8 product
   assign rounded = prod_ff + iiu_pkg::PROD_W'(iiu_pkg::ROUND_HALF);
   assign offset  = rounded[iiu_pkg::PROD_W-1:iiu_pkg::FRAC_W];
   assign mean_s  = $signed({{(iiu_pkg::BOUND_W-iiu_pkg::MEAN_W){1'b0}}, s2_mean_ff});
   assign off_s   = $signed({{(iiu_pkg::BOUND_W-iiu_pkg::OFF_W){1'b0}}, offset});
   assign lo_raw  = mean_s - off_s;
   assign hi_raw  = mean_s + off_s;

   always_comb begin
      lo_adj = lo_raw;
      hi_adj = hi_raw;
      if (s2_open_ff == iiu_pkg::OPEN_LOW && lo_raw > $signed(iiu_pkg::BOUND_W'(0))) begin
         lo_adj = '0;
      end
      if (s2_open_ff == iiu_pkg::OPEN_HIGH && hi_raw < iiu_pkg::TOP_LEVEL) begin
         hi_adj = iiu_pkg::TOP_LEVEL;
      end
   end

   assign push    = s2_go;
   assign item.op = s2_op_ff;
   assign item.lo = lo_adj;
   assign item.hi = hi_adj;

endmodule

/* rtl/iiu_queue.sv */
// Short queue between front end and table engine.
// Depends on iiu_pkg; written by iiu_front, drained by iiu_back.
module iiu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  iiu_pkg::item_type   push_item,
   input  logic                pop,
   output iiu_pkg::item_type   head_item,
   output iiu_pkg::qstat_type  qstat
);

   localparam int PTR_W = $clog2(iiu_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(iiu_pkg::QUEUE_DEPTH + 1);

   iiu_pkg::item_type  slot_ff [iiu_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
      end
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

   assign head_item   = slot_ff[rd_ptr_ff];
   assign qstat.full  = (cnt_ff == CNT_W'(iiu_pkg::QUEUE_DEPTH));
   assign qstat.avail = (cnt_ff != '0);

endmodule

/* rtl/iiu_back.sv */
// Table engine: sorted chain of interval cells, merge/insert sequencer and readout.
// Depends on iiu_pkg; drains iiu_queue and drives the result beats.
module iiu_back #(
   parameter int MAX_INTERVALS = iiu_pkg::MAX_INTERVALS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  iiu_pkg::qstat_type              qstat,
   input  iiu_pkg::item_type               head_item,
   output logic                            pop,
   output logic                            rsp_valid,
   output logic [iiu_pkg::LOW_W-1:0]       rsp_range_low,
   output logic [iiu_pkg::HIGH_W-1:0]      rsp_range_high,
   output logic                            rsp_none_left,
   output logic                            rsp_overflowed,
   output logic                            rsp_last_one
);

   localparam int N     = MAX_INTERVALS;
   localparam int CNT_W = $clog2(N + 1);
   localparam int BW    = iiu_pkg::BOUND_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CMP  = 3'd1;
   localparam logic [2:0] ST_ACT  = 3'd2;
   localparam logic [2:0] ST_PACK = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic signed [BW-1:0]   pend_lo_ff, pend_hi_ff;

   logic signed [BW-1:0]   lo_ff [N];
   logic signed [BW-1:0]   hi_ff [N];
   logic signed [BW-1:0]   lo_in [N];
   logic signed [BW-1:0]   hi_in [N];
   logic signed [BW-1:0]   up_lo [N];
   logic signed [BW-1:0]   up_hi [N];
   logic signed [BW-1:0]   dn_lo [N];
   logic signed [BW-1:0]   dn_hi [N];

   logic [N-1:0] below_ff, ovl_ff, kill_ff, shift_ff;
   logic [N-1:0] kill_in, shift_in;
   logic [N-1:0] below_c, ovl_c, vld, first_v, last_v, ins_at, up_kill, up_shift;

   logic [BW-1:0]          sel_lo_u, sel_hi_u;
   logic signed [BW-1:0]   union_lo, union_hi;
   logic                   any_ovl, any_kill, full;
   logic                   do_merge, do_insert, do_pack, do_pop;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [iiu_pkg::LOW_W-1:0]  rsp_lo_ff, rsp_lo_in;
   logic [iiu_pkg::HIGH_W-1:0] rsp_hi_ff, rsp_hi_in;
   logic                       rsp_none_ff, rsp_none_in;
   logic                       rsp_ovf_ff, rsp_ovf_in;
   logic                       rsp_last_ff, rsp_last_in;

   // per-cell compares and neighbor links
   for (genvar k = 0; k < N; k++) begin : g_cell
      assign vld[k]     = count_ff > CNT_W'(k);
      assign below_c[k] = vld[k] && (hi_ff[k] < pend_lo_ff);
      assign ovl_c[k]   = vld[k] && !below_c[k] && (lo_ff[k] <= pend_hi_ff);
      if (k == 0) begin : g_bot
         assign dn_lo[k]   = pend_lo_ff;
         assign dn_hi[k]   = pend_hi_ff;
         assign first_v[k] = ovl_ff[k];
         assign ins_at[k]  = !below_ff[k];
      end else begin : g_mid_lo
         assign dn_lo[k]   = lo_ff[k-1];
         assign dn_hi[k]   = hi_ff[k-1];
         assign first_v[k] = ovl_ff[k] && !ovl_ff[k-1];
         assign ins_at[k]  = !below_ff[k] && below_ff[k-1];
      end
      if (k == N - 1) begin : g_top
         assign up_lo[k]    = '0;
         assign up_hi[k]    = '0;
         assign up_kill[k]  = 1'b0;
         assign up_shift[k] = 1'b0;
         assign last_v[k]   = ovl_ff[k];
      end else begin : g_mid_hi
         assign up_lo[k]    = lo_ff[k+1];
         assign up_hi[k]    = hi_ff[k+1];
         assign up_kill[k]  = kill_ff[k+1];
         assign up_shift[k] = shift_ff[k+1];
         assign last_v[k]   = ovl_ff[k] && !ovl_ff[k+1];
      end
   end

   always_comb begin
      sel_lo_u = '0;
      sel_hi_u = '0;
      for (int k = 0; k < N; k++) begin
         sel_lo_u = sel_lo_u | (first_v[k] ? lo_ff[k] : '0);
         sel_hi_u = sel_hi_u | (last_v[k] ? hi_ff[k] : '0);
      end
   end

   assign any_ovl  = |ovl_ff;
   assign any_kill = |(ovl_ff & ~first_v);
   assign full     = (count_ff == CNT_W'(N));
   assign union_lo = ($signed(sel_lo_u) < pend_lo_ff) ? $signed(sel_lo_u) : pend_lo_ff;
   assign union_hi = ($signed(sel_hi_u) > pend_hi_ff) ? $signed(sel_hi_u) : pend_hi_ff;

   assign do_merge  = (state_ff == ST_ACT) && any_ovl;
   assign do_insert = (state_ff == ST_ACT) && !any_ovl && !full;
   assign do_pack   = (state_ff == ST_PACK);
   assign do_pop    = (state_ff == ST_EMIT) && (count_ff != '0);

   // cell chain update
   always_comb begin
      for (int k = 0; k < N; k++) begin
         lo_in[k]    = lo_ff[k];
         hi_in[k]    = hi_ff[k];
         kill_in[k]  = kill_ff[k];
         shift_in[k] = shift_ff[k];
         if (do_merge) begin
            if (first_v[k]) begin
               lo_in[k] = union_lo;
               hi_in[k] = union_hi;
            end
            kill_in[k]  = ovl_ff[k] && !first_v[k];
            shift_in[k] = vld[k] && !below_ff[k] && !first_v[k];
         end else if (do_insert) begin
            if (ins_at[k]) begin
               lo_in[k] = pend_lo_ff;
               hi_in[k] = pend_hi_ff;
            end else if (!below_ff[k]) begin
               lo_in[k] = dn_lo[k];
               hi_in[k] = dn_hi[k];
            end
         end else if (do_pack) begin
            if (shift_ff[k]) begin
               lo_in[k]    = up_lo[k];
               hi_in[k]    = up_hi[k];
               kill_in[k]  = up_kill[k];
               shift_in[k] = up_shift[k];
            end
         end else if (do_pop) begin
            lo_in[k] = up_lo[k];
            hi_in[k] = up_hi[k];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      pop          = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_lo_in    = '0;
      rsp_hi_in    = '0;
      rsp_none_in  = 1'b0;
      rsp_ovf_in   = ovf_ff;
      rsp_last_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (qstat.avail) begin
               pop      = 1'b1;
               state_in = (head_item.op == iiu_pkg::OP_EMIT) ? ST_EMIT : ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_ACT;
         end
         ST_ACT: begin
            state_in = ST_IDLE;
            if (any_ovl) begin
               if (any_kill) state_in = ST_PACK;
            end else if (full) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_PACK: begin
            count_in = count_ff - CNT_W'(1);
            if (!(|kill_in)) state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (count_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_none_in  = 1'b1;
               rsp_last_in  = 1'b1;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               count_in = count_ff - CNT_W'(1);
               // stored highs rise along the chain, so only the tail can be emitted
               if (!hi_ff[0][BW-1] && hi_ff[0] != '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_lo_in    = lo_ff[0][BW-1] ? '0 : lo_ff[0][iiu_pkg::LOW_W-1:0];
                  rsp_hi_in    = hi_ff[0][iiu_pkg::HIGH_W-1:0];
                  rsp_last_in  = (count_ff == CNT_W'(1));
               end else if (count_ff == CNT_W'(1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_none_in  = 1'b1;
                  rsp_last_in  = 1'b1;
               end
               if (count_ff == CNT_W'(1)) begin
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kill_ff      <= '0;
         shift_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         kill_ff      <= kill_in;
         shift_ff     <= shift_in;
      end
      if (pop) begin
         pend_lo_ff <= head_item.lo;
         pend_hi_ff <= head_item.hi;
      end
      if (state_ff == ST_CMP) begin
         below_ff <= below_c;
         ovl_ff   <= ovl_c;
      end
      for (int k = 0; k < N; k++) begin
         lo_ff[k] <= lo_in[k];
         hi_ff[k] <= hi_in[k];
      end
      rsp_lo_ff   <= rsp_lo_in;
      rsp_hi_ff   <= rsp_hi_in;
      rsp_none_ff <= rsp_none_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_range_low  = rsp_lo_ff;
   assign rsp_range_high = rsp_hi_ff;
   assign rsp_none_left  = rsp_none_ff;
   assign rsp_overflowed = rsp_ovf_ff;
   assign rsp_last_one   = rsp_last_ff;

endmodule

/* rtl/intensity_interval_union_core.sv */
// Top level of the intensity interval union block: CSR port, front end, queue, table engine.
// Depends on iiu_pkg, iiu_front, iiu_queue, iiu_back.
//
//   channel   ports                          beat taken when
//   command   start/busy, req_*              start && !busy
//   result    rsp_valid, rsp_*               rsp_valid (one cycle, no stall)
//   csr       psel/penable/pwrite/paddr...   psel && penable && pwrite (pready tied high)
//
// Front end: a command passes s1 then s2 and is pushed; both wait while the queue is full.
// Add: IDLE, CMP, ACT, then PACK while swallowed intervals close up. Emit: one result beat
// per surviving interval, else a none-left beat. busy rises only while the queue is full.
// Reset clears control state; table contents stay unknown until written.
// Results cannot be held off; every beat is shown for exactly one cycle.
module intensity_interval_union_core #(
   parameter int MAX_INTERVALS = iiu_pkg::MAX_INTERVALS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_operation,
   input  logic [iiu_pkg::MEAN_W-1:0]         req_class_mean,
   input  logic [iiu_pkg::SPREAD_W-1:0]       req_class_spread,
   input  logic [iiu_pkg::OPEN_W-1:0]         req_open_end,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [iiu_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [iiu_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [iiu_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output logic                               rsp_valid,
   output logic [iiu_pkg::LOW_W-1:0]          rsp_range_low,
   output logic [iiu_pkg::HIGH_W-1:0]         rsp_range_high,
   output logic                               rsp_none_left,
   output logic                               rsp_overflowed,
   output logic                               rsp_last_one
);

   logic [iiu_pkg::FACTOR_W-1:0] factor_ff;
   logic                         csr_wr;
   logic                         csr_hit;
   logic                         push, pop;
   iiu_pkg::item_type            push_item, head_item;
   iiu_pkg::qstat_type           qstat;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[iiu_pkg::CSR_ADDR_W-1] == iiu_pkg::REG_SPREAD_FACTOR);
   assign csr_wr  = psel && penable && pwrite && pready && csr_hit;
   assign prdata  = csr_hit ? iiu_pkg::CSR_DATA_W'(factor_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= iiu_pkg::FACTOR_RESET;
      end else if (csr_wr) begin
         factor_ff <= pwdata[iiu_pkg::FACTOR_W-1:0];
      end
   end

   iiu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_class_mean   (req_class_mean),
      .req_class_spread (req_class_spread),
      .req_open_end     (req_open_end),
      .spread_factor    (factor_ff),
      .qstat            (qstat),
      .push             (push),
      .item             (push_item)
   );

   iiu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   iiu_back #(
      .MAX_INTERVALS (MAX_INTERVALS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .qstat          (qstat),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_range_low  (rsp_range_low),
      .rsp_range_high (rsp_range_high),
      .rsp_none_left  (rsp_none_left),
      .rsp_overflowed (rsp_overflowed),
      .rsp_last_one   (rsp_last_one)
   );

endmodule
